@@ hw/rtl/opkrm_pkg.sv @@
// Package for the omega-phi-kappa rotation matrix pipeline.
// Holds the CORDIC constants, the arctangent table and Q30 rounding.
// No dependencies.
package opkrm_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int Q_W          = 34;
   localparam int P_W          = 2 * Q_W;
   localparam int NUM_LANES    = 3;
   localparam int LANE_OMEGA   = 0;
   localparam int LANE_PHI     = 1;
   localparam int LANE_KAPPA   = 2;
   localparam int NUM_OUT      = 9;
   localparam int SUM_W        = Q_W + 2;

   localparam logic signed [Q_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic [26:0]           DEG_TO_RAD  = 27'd74961321;

   typedef logic signed [Q_W-1:0]   q30_type;
   typedef logic signed [P_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   function automatic q30_type atan_q30(input int idx);
      q30_type v;
      unique case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         24: v = 34'sh00000003F;
         25: v = 34'sh00000001F;
         26: v = 34'sh00000000F;
         27: v = 34'sh000000008;
         28: v = 34'sh000000004;
         29: v = 34'sh000000002;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round a Q60 product to Q30, half toward +infinity
   function automatic q30_type rnd30(input prod_type p);
      prod_type t;
      t = (p + (68'sd1 <<< 29)) >>> 30;
      return q30_type'(t);
   endfunction

endpackage

@@ hw/rtl/opk_angles_to_rotation_matrix.sv @@
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Stages: angle reduction (5), one CORDIC iteration per stage (30), matrix (6).
// Reset clears only the valid chain; payload registers run free.
// Top level of the omega-phi-kappa rotation matrix pipeline.
// Depends on opkrm_pkg.
module opk_angles_to_rotation_matrix #(
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int OUT_FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [24:0] req_omega_deg,
   input  logic signed [24:0] req_phi_deg,
   input  logic signed [24:0] req_kappa_deg,
   output logic               rsp_strobe,
   output logic signed [17:0] rsp_rot_00,
   output logic signed [17:0] rsp_rot_01,
   output logic signed [17:0] rsp_rot_02,
   output logic signed [17:0] rsp_rot_10,
   output logic signed [17:0] rsp_rot_11,
   output logic signed [17:0] rsp_rot_12,
   output logic signed [17:0] rsp_rot_20,
   output logic signed [17:0] rsp_rot_21,
   output logic signed [17:0] rsp_rot_22
);
   import opkrm_pkg::*;

   localparam longint unsigned FULL    = 64'd360 << ANGLE_FRAC_BITS;
   localparam longint unsigned HALF    = 64'd180 << ANGLE_FRAC_BITS;
   localparam longint unsigned QUARTER = 64'd90 << ANGLE_FRAC_BITS;
   localparam longint unsigned RECIP   = (64'd1 << 25) / FULL;
   localparam int              QW      = $clog2(((64'd1 << 24) / FULL) + 2);
   localparam int              RAD_SH  = ANGLE_FRAC_BITS + 2;
   localparam logic [51:0]     RAD_RND = 52'd1 << (ANGLE_FRAC_BITS + 1);
   localparam int              OUT_SH  = 30 - OUT_FRAC_BITS;
   localparam logic signed [SUM_W:0] OUT_RND =
      (OUT_SH > 0) ? ((SUM_W + 1)'(1) <<< ((OUT_SH > 0) ? OUT_SH - 1 : 0)) : '0;
   localparam logic signed [SUM_W:0] OUT_ONE = (SUM_W + 1)'(1) <<< OUT_FRAC_BITS;
   localparam int              FRONT   = 5;
   localparam int              DEPTH   = FRONT + CORDIC_STEPS + 6;

   function automatic logic [17:0] to_out(input sum_type v);
      logic signed [SUM_W:0] t;
      t = ((SUM_W + 1)'(v) + OUT_RND) >>> OUT_SH;
      if (t > OUT_ONE) t = OUT_ONE;
      if (t < -OUT_ONE) t = -OUT_ONE;
      return t[17:0];
   endfunction

   logic              vld_ff [DEPTH];
   logic signed [24:0] ang_w [NUM_LANES];

   logic [24:0]    mag1_ff [NUM_LANES];
   logic           neg1_ff [NUM_LANES];
   logic [QW-1:0]  q1_ff   [NUM_LANES];
   logic [24:0]    rem2_ff [NUM_LANES];
   logic           neg2_ff [NUM_LANES];
   logic [24:0]    a3_ff   [NUM_LANES];
   logic           s3_ff   [NUM_LANES];
   logic           nc3_ff  [NUM_LANES];
   logic [51:0]    p4_ff   [NUM_LANES];
   logic           s4_ff   [NUM_LANES];
   logic           nc4_ff  [NUM_LANES];

   q30_type cx_ff [CORDIC_STEPS+1][NUM_LANES];
   q30_type cy_ff [CORDIC_STEPS+1][NUM_LANES];
   q30_type cz_ff [CORDIC_STEPS+1][NUM_LANES];
   logic    cn_ff [CORDIC_STEPS+1][NUM_LANES];

   q30_type sin_ff [NUM_LANES];
   q30_type cos_ff [NUM_LANES];

   prod_type pa_sosp_ff, pa_cosp_ff, pa_cpck_ff, pa_cosk_ff, pa_sosk_ff;
   prod_type pa_cpsk_ff, pa_cock_ff, pa_sock_ff, pa_socp_ff, pa_cocp_ff;
   q30_type  pa_sp_ff, pa_sk_ff, pa_ck_ff;

   q30_type  pb_sosp_ff, pb_cosp_ff, pb_cpck_ff, pb_cosk_ff, pb_sosk_ff;
   q30_type  pb_cpsk_ff, pb_cock_ff, pb_sock_ff, pb_socp_ff, pb_cocp_ff;
   q30_type  pb_sp_ff, pb_sk_ff, pb_ck_ff;

   prod_type pc_sospck_ff, pc_sospsk_ff, pc_cospck_ff, pc_cospsk_ff;
   q30_type  pc_cpck_ff, pc_cosk_ff, pc_sosk_ff, pc_cpsk_ff, pc_cock_ff;
   q30_type  pc_sock_ff, pc_socp_ff, pc_cocp_ff, pc_sp_ff;

   sum_type  md_ff [NUM_OUT];
   sum_type  md_in [NUM_OUT];
   logic [17:0] out_ff [NUM_OUT];

   assign busy = 1'b0;
   assign ang_w[LANE_OMEGA] = req_omega_deg;
   assign ang_w[LANE_PHI]   = req_phi_deg;
   assign ang_w[LANE_KAPPA] = req_kappa_deg;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= start;
         for (int k = 1; k < DEPTH; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [24:0] mag_in;
      logic [49:0] qprod_in;
      logic [63:0] rem0_in, rem_in;
      logic        over_in, fold_in;
      logic [24:0] a_in, af_in;
      logic [51:0] rad_in;
      q30_type     zmag_in;

      always_comb begin
         mag_in   = ang_w[l][24] ? 25'(-ang_w[l]) : 25'(ang_w[l]);
         qprod_in = 50'(mag_in) * 50'(RECIP);
         rem0_in  = 64'(mag1_ff[l]) - 64'(q1_ff[l]) * FULL;
         rem_in   = (rem0_in >= FULL) ? rem0_in - FULL : rem0_in;
         over_in  = 64'(rem2_ff[l]) > HALF;
         a_in     = over_in ? 25'(FULL - 64'(rem2_ff[l])) : rem2_ff[l];
         fold_in  = 64'(a_in) > QUARTER;
         af_in    = fold_in ? 25'(HALF - 64'(a_in)) : a_in;
         rad_in   = (p4_ff[l] + RAD_RND) >> RAD_SH;
         zmag_in  = q30_type'(rad_in);
      end

      always_ff @(posedge clock) begin
         mag1_ff[l]   <= mag_in;
         neg1_ff[l]   <= ang_w[l][24];
         q1_ff[l]     <= QW'(qprod_in >> 25);
         rem2_ff[l]   <= rem_in[24:0];
         neg2_ff[l]   <= neg1_ff[l];
         a3_ff[l]     <= af_in;
         s3_ff[l]     <= neg2_ff[l] ^ over_in;
         nc3_ff[l]    <= fold_in;
         p4_ff[l]     <= 52'(a3_ff[l]) * 52'(DEG_TO_RAD);
         s4_ff[l]     <= s3_ff[l];
         nc4_ff[l]    <= nc3_ff[l];
         cx_ff[0][l]  <= CORDIC_GAIN;
         cy_ff[0][l]  <= '0;
         cz_ff[0][l]  <= s4_ff[l] ? -zmag_in : zmag_in;
         cn_ff[0][l]  <= nc4_ff[l];
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (!cz_ff[i][l][Q_W-1]) begin
               cx_ff[i+1][l] <= cx_ff[i][l] - (cy_ff[i][l] >>> i);
               cy_ff[i+1][l] <= cy_ff[i][l] + (cx_ff[i][l] >>> i);
               cz_ff[i+1][l] <= cz_ff[i][l] - atan_q30(i);
            end else begin
               cx_ff[i+1][l] <= cx_ff[i][l] + (cy_ff[i][l] >>> i);
               cy_ff[i+1][l] <= cy_ff[i][l] - (cx_ff[i][l] >>> i);
               cz_ff[i+1][l] <= cz_ff[i][l] + atan_q30(i);
            end
            cn_ff[i+1][l] <= cn_ff[i][l];
         end
      end

      always_ff @(posedge clock) begin
         sin_ff[l] <= cy_ff[CORDIC_STEPS][l];
         cos_ff[l] <= cn_ff[CORDIC_STEPS][l] ? -cx_ff[CORDIC_STEPS][l]
                                              : cx_ff[CORDIC_STEPS][l];
      end
   end

   always_comb begin
      md_in[0] = SUM_W'(pc_cpck_ff);
      md_in[1] = SUM_W'(pc_cosk_ff) + SUM_W'(rnd30(pc_sospck_ff));
      md_in[2] = SUM_W'(pc_sosk_ff) - SUM_W'(rnd30(pc_cospck_ff));
      md_in[3] = -SUM_W'(pc_cpsk_ff);
      md_in[4] = SUM_W'(pc_cock_ff) - SUM_W'(rnd30(pc_sospsk_ff));
      md_in[5] = SUM_W'(pc_sock_ff) + SUM_W'(rnd30(pc_cospsk_ff));
      md_in[6] = SUM_W'(pc_sp_ff);
      md_in[7] = -SUM_W'(pc_socp_ff);
      md_in[8] = SUM_W'(pc_cocp_ff);
   end

   always_ff @(posedge clock) begin
      pa_sosp_ff <= P_W'(sin_ff[LANE_OMEGA]) * P_W'(sin_ff[LANE_PHI]);
      pa_cosp_ff <= P_W'(cos_ff[LANE_OMEGA]) * P_W'(sin_ff[LANE_PHI]);
      pa_cpck_ff <= P_W'(cos_ff[LANE_PHI]) * P_W'(cos_ff[LANE_KAPPA]);
      pa_cosk_ff <= P_W'(cos_ff[LANE_OMEGA]) * P_W'(sin_ff[LANE_KAPPA]);
      pa_sosk_ff <= P_W'(sin_ff[LANE_OMEGA]) * P_W'(sin_ff[LANE_KAPPA]);
      pa_cpsk_ff <= P_W'(cos_ff[LANE_PHI]) * P_W'(sin_ff[LANE_KAPPA]);
      pa_cock_ff <= P_W'(cos_ff[LANE_OMEGA]) * P_W'(cos_ff[LANE_KAPPA]);
      pa_sock_ff <= P_W'(sin_ff[LANE_OMEGA]) * P_W'(cos_ff[LANE_KAPPA]);
      pa_socp_ff <= P_W'(sin_ff[LANE_OMEGA]) * P_W'(cos_ff[LANE_PHI]);
      pa_cocp_ff <= P_W'(cos_ff[LANE_OMEGA]) * P_W'(cos_ff[LANE_PHI]);
      pa_sp_ff   <= sin_ff[LANE_PHI];
      pa_sk_ff   <= sin_ff[LANE_KAPPA];
      pa_ck_ff   <= cos_ff[LANE_KAPPA];

      pb_sosp_ff <= rnd30(pa_sosp_ff);
      pb_cosp_ff <= rnd30(pa_cosp_ff);
      pb_cpck_ff <= rnd30(pa_cpck_ff);
      pb_cosk_ff <= rnd30(pa_cosk_ff);
      pb_sosk_ff <= rnd30(pa_sosk_ff);
      pb_cpsk_ff <= rnd30(pa_cpsk_ff);
      pb_cock_ff <= rnd30(pa_cock_ff);
      pb_sock_ff <= rnd30(pa_sock_ff);
      pb_socp_ff <= rnd30(pa_socp_ff);
      pb_cocp_ff <= rnd30(pa_cocp_ff);
      pb_sp_ff   <= pa_sp_ff;
      pb_sk_ff   <= pa_sk_ff;
      pb_ck_ff   <= pa_ck_ff;

      pc_sospck_ff <= P_W'(pb_sosp_ff) * P_W'(pb_ck_ff);
      pc_sospsk_ff <= P_W'(pb_sosp_ff) * P_W'(pb_sk_ff);
      pc_cospck_ff <= P_W'(pb_cosp_ff) * P_W'(pb_ck_ff);
      pc_cospsk_ff <= P_W'(pb_cosp_ff) * P_W'(pb_sk_ff);
      pc_cpck_ff   <= pb_cpck_ff;
      pc_cosk_ff   <= pb_cosk_ff;
      pc_sosk_ff   <= pb_sosk_ff;
      pc_cpsk_ff   <= pb_cpsk_ff;
      pc_cock_ff   <= pb_cock_ff;
      pc_sock_ff   <= pb_sock_ff;
      pc_socp_ff   <= pb_socp_ff;
      pc_cocp_ff   <= pb_cocp_ff;
      pc_sp_ff     <= pb_sp_ff;

      for (int j = 0; j < NUM_OUT; j++) begin
         md_ff[j]  <= md_in[j];
         out_ff[j] <= to_out(md_ff[j]);
      end
   end

   assign rsp_strobe = vld_ff[DEPTH-1];
   assign rsp_rot_00 = out_ff[0];
   assign rsp_rot_01 = out_ff[1];
   assign rsp_rot_02 = out_ff[2];
   assign rsp_rot_10 = out_ff[3];
   assign rsp_rot_11 = out_ff[4];
   assign rsp_rot_12 = out_ff[5];
   assign rsp_rot_20 = out_ff[6];
   assign rsp_rot_21 = out_ff[7];
   assign rsp_rot_22 = out_ff[8];

endmodule
